### sv/assert_macros.svh
// Assertion macros shared by the arithmetic unit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked property with an active-low reset guard.
`define CAU_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Overlapping implication built on the generic form.
`define CAU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    `CAU_ASSERT(label, clk, rst_n, ((ante) |-> (cons)))

`endif

### sv/cau_pkg.sv
// Package with the operation codes of the complex arithmetic unit.
package cau_pkg;

    localparam int KIND_W = 3;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD    = 3'd0,
        KIND_SUB    = 3'd1,
        KIND_MUL_RE = 3'd2,
        KIND_MUL_IM = 3'd3,
        KIND_CMUL   = 3'd4,
        KIND_MAG    = 3'd5
    } t_kind;

endpackage

### sv/complex_arithmetic_unit.sv
// Pipelined complex arithmetic unit on signed fixed-point operands.
//
// A command beat is taken at each rising edge with start high and busy low.
// busy is always low, so a new command may be issued in every cycle.
// The command selects add, subtract, real scale, imaginary scale, complex
// multiply or magnitude, applied to i_a_re/i_a_im with i_b_re/i_b_im or i_scale.
// Each result beat is shown for exactly one cycle with o_done high.
// One result leaves per cycle.
// The depth is set by an input register, a multiplier stage, a combine stage
// and a square root pipeline that settles one root bit per stage.
// All operations travel through the full depth so results stay in order.
// Reset clears every valid bit; commands in flight are dropped.
// The receiver cannot stall, so no result is ever held back.
module complex_arithmetic_unit #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [cau_pkg::KIND_W-1:0]         i_kind,
    input  logic signed [DATA_WIDTH-1:0]       i_a_re,
    input  logic signed [DATA_WIDTH-1:0]       i_a_im,
    input  logic signed [DATA_WIDTH-1:0]       i_b_re,
    input  logic signed [DATA_WIDTH-1:0]       i_b_im,
    input  logic signed [DATA_WIDTH-1:0]       i_scale,
    output logic                               o_done,
    output logic signed [DATA_WIDTH-1:0]       o_res_re,
    output logic signed [DATA_WIDTH-1:0]       o_res_im,
    output logic [DATA_WIDTH-1:0]              o_magnitude,
    output logic                               o_overflow
);
    import cau_pkg::*;
    `include "assert_macros.svh"

    localparam int W   = DATA_WIDTH;
    localparam int P   = 2 * DATA_WIDTH;
    localparam int V   = 2 * DATA_WIDTH + 1;
    localparam int LAT = DATA_WIDTH + 3;
    localparam logic signed [W-1:0] SAT_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] SAT_MIN = {1'b1, {(W-1){1'b0}}};

    function automatic logic [W+2:0] sq_step(input logic [W+1:0] rem_in,
                                             input logic [W-1:0] root_in,
                                             input logic [1:0]   pair);
        logic [W+1:0] rem_sh;
        logic [W+1:0] trial;
        rem_sh = {rem_in[W-1:0], pair};
        trial  = {root_in, 2'b01};
        if (rem_sh >= trial) begin
            return {1'b1, rem_sh - trial};
        end
        return {1'b0, rem_sh};
    endfunction

    function automatic logic [W:0] sat_wide(input logic signed [V-1:0] v);
        logic [V-W:0] hi;
        hi = v[V-1:W-1];
        if ((&hi) || !(|hi)) begin
            return {1'b0, v[W-1:0]};
        end
        return {1'b1, (v[V-1] ? SAT_MIN : SAT_MAX)};
    endfunction

    // Input register with multiplier operand selection.
    logic                  r_s1_vld;
    t_kind                 r_s1_kind;
    logic signed [W-1:0]   r_s1_ar, r_s1_ai, r_s1_br, r_s1_bi;
    logic signed [W-1:0]   r_s1_op0, r_s1_op1, r_s1_op2, r_s1_op3;
    logic signed [W-1:0]   n_s1_op0, n_s1_op1, n_s1_op2, n_s1_op3;

    // Product stage.
    logic                  r_s2_vld;
    t_kind                 r_s2_kind;
    logic signed [P-1:0]   r_s2_m0, r_s2_m1, r_s2_m2, r_s2_m3;
    logic signed [W:0]     r_s2_sum_re, r_s2_sum_im;
    logic signed [W:0]     n_s2_sum_re, n_s2_sum_im;

    // Combine stage.
    logic                  r_s3_vld;
    logic signed [V-1:0]   r_s3_re, r_s3_im;
    logic [P-1:0]          r_s3_sq;
    logic signed [V-1:0]   n_s3_re, n_s3_im;
    logic [P-1:0]          n_s3_sq;
    logic signed [V-1:0]   d_re, d_im;

    // Square root stages with the saturated results riding along.
    logic                  r_vld  [W];
    logic [W+1:0]          r_rem  [W];
    logic [W-1:0]          r_root [W];
    logic [P-1:0]          r_nr   [W-1];
    logic signed [W-1:0]   r_re   [W];
    logic signed [W-1:0]   r_im   [W];
    logic                  r_ovf  [W];
    logic [W+1:0]          n_rem  [W];
    logic [W-1:0]          n_root [W];
    logic [P-1:0]          n_nr   [W-1];
    logic [W:0]            sat_re, sat_im;

    assign busy = 1'b0;

    always_comb begin
        n_s1_op0 = '0;
        n_s1_op1 = '0;
        n_s1_op2 = '0;
        n_s1_op3 = '0;
        case (t_kind'(i_kind))
            KIND_MUL_RE: begin
                n_s1_op0 = i_scale;
                n_s1_op3 = i_scale;
            end
            KIND_MUL_IM: begin
                n_s1_op1 = i_scale;
                n_s1_op2 = i_scale;
            end
            KIND_CMUL: begin
                n_s1_op0 = i_b_re;
                n_s1_op1 = i_b_im;
                n_s1_op2 = i_b_im;
                n_s1_op3 = i_b_re;
            end
            KIND_MAG: begin
                n_s1_op0 = i_a_re;
                n_s1_op1 = i_a_im;
            end
            default: begin
                n_s1_op0 = '0;
            end
        endcase
    end

    always_comb begin
        if (r_s1_kind == KIND_SUB) begin
            n_s2_sum_re = $signed({r_s1_ar[W-1], r_s1_ar}) - $signed({r_s1_br[W-1], r_s1_br});
            n_s2_sum_im = $signed({r_s1_ai[W-1], r_s1_ai}) - $signed({r_s1_bi[W-1], r_s1_bi});
        end else begin
            n_s2_sum_re = $signed({r_s1_ar[W-1], r_s1_ar}) + $signed({r_s1_br[W-1], r_s1_br});
            n_s2_sum_im = $signed({r_s1_ai[W-1], r_s1_ai}) + $signed({r_s1_bi[W-1], r_s1_bi});
        end
    end

    always_comb begin
        d_re    = $signed({r_s2_m0[P-1], r_s2_m0}) - $signed({r_s2_m1[P-1], r_s2_m1});
        d_im    = $signed({r_s2_m2[P-1], r_s2_m2}) + $signed({r_s2_m3[P-1], r_s2_m3});
        n_s3_re = '0;
        n_s3_im = '0;
        n_s3_sq = '0;
        case (r_s2_kind)
            KIND_ADD, KIND_SUB: begin
                n_s3_re = $signed({{W{r_s2_sum_re[W]}}, r_s2_sum_re});
                n_s3_im = $signed({{W{r_s2_sum_im[W]}}, r_s2_sum_im});
            end
            KIND_MUL_RE, KIND_MUL_IM, KIND_CMUL: begin
                n_s3_re = d_re >>> FRAC_BITS;
                n_s3_im = d_im >>> FRAC_BITS;
            end
            KIND_MAG: begin
                n_s3_sq = $unsigned(r_s2_m0) + $unsigned(r_s2_m1);
            end
            default: begin
                n_s3_sq = '0;
            end
        endcase
    end

    always_comb begin
        logic [W+2:0] st;
        sat_re    = sat_wide(r_s3_re);
        sat_im    = sat_wide(r_s3_im);
        st        = sq_step('0, '0, r_s3_sq[P-1 -: 2]);
        n_rem[0]  = st[W+1:0];
        n_root[0] = {{(W-1){1'b0}}, st[W+2]};
        n_nr[0]   = {r_s3_sq[P-3:0], 2'b00};
        for (int j = 1; j < W; j++) begin
            st        = sq_step(r_rem[j-1], r_root[j-1], r_nr[j-1][P-1 -: 2]);
            n_rem[j]  = st[W+1:0];
            n_root[j] = {r_root[j-1][W-2:0], st[W+2]};
        end
        for (int j = 1; j < W - 1; j++) begin
            n_nr[j] = {r_nr[j-1][P-3:0], 2'b00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            for (int j = 0; j < W; j++) begin
                r_vld[j] <= 1'b0;
            end
        end else begin
            r_s1_vld <= start && !busy;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_vld[0] <= r_s3_vld;
            for (int j = 1; j < W; j++) begin
                r_vld[j] <= r_vld[j-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_kind   <= t_kind'(i_kind);
        r_s1_ar     <= i_a_re;
        r_s1_ai     <= i_a_im;
        r_s1_br     <= i_b_re;
        r_s1_bi     <= i_b_im;
        r_s1_op0    <= n_s1_op0;
        r_s1_op1    <= n_s1_op1;
        r_s1_op2    <= n_s1_op2;
        r_s1_op3    <= n_s1_op3;
        r_s2_kind   <= r_s1_kind;
        r_s2_m0     <= P'(r_s1_ar) * P'(r_s1_op0);
        r_s2_m1     <= P'(r_s1_ai) * P'(r_s1_op1);
        r_s2_m2     <= P'(r_s1_ar) * P'(r_s1_op2);
        r_s2_m3     <= P'(r_s1_ai) * P'(r_s1_op3);
        r_s2_sum_re <= n_s2_sum_re;
        r_s2_sum_im <= n_s2_sum_im;
        r_s3_re     <= n_s3_re;
        r_s3_im     <= n_s3_im;
        r_s3_sq     <= n_s3_sq;
        r_re[0]     <= sat_re[W-1:0];
        r_im[0]     <= sat_im[W-1:0];
        r_ovf[0]    <= sat_re[W] | sat_im[W];
        for (int j = 0; j < W; j++) begin
            r_rem[j]  <= n_rem[j];
            r_root[j] <= n_root[j];
        end
        for (int j = 0; j < W - 1; j++) begin
            r_nr[j] <= n_nr[j];
        end
        for (int j = 1; j < W; j++) begin
            r_re[j]  <= r_re[j-1];
            r_im[j]  <= r_im[j-1];
            r_ovf[j] <= r_ovf[j-1];
        end
    end

    assign o_done      = r_vld[W-1];
    assign o_res_re    = r_re[W-1];
    assign o_res_im    = r_im[W-1];
    assign o_magnitude = r_root[W-1];
    assign o_overflow  = r_ovf[W-1];

    logic res_zero;
    logic res_sat;

    assign res_zero = (o_res_re == '0) && (o_res_im == '0) && !o_overflow;
    assign res_sat  = (o_res_re == SAT_MAX) || (o_res_re == SAT_MIN) ||
                      (o_res_im == SAT_MAX) || (o_res_im == SAT_MIN);

    `CAU_ASSERT_IMPL(a_latency, i_clk, i_rst_n, start && !busy, ##LAT o_done)
    `CAU_ASSERT_IMPL(a_mag_only, i_clk, i_rst_n, o_done && (o_magnitude != '0), res_zero)
    `CAU_ASSERT_IMPL(a_ovf_sat, i_clk, i_rst_n, o_done && o_overflow, res_sat)
    `CAU_ASSERT_IMPL(a_rem_bound, i_clk, i_rst_n, o_done, r_rem[W-1] <= {1'b0, r_root[W-1], 1'b0})

endmodule

### test/tb_complex_arithmetic_unit.sv
// Self-checking testbench for the complex arithmetic unit, with its own predictor.
`timescale 1ns / 100ps

module tb_complex_arithmetic_unit;
    import cau_pkg::*;

    localparam int DW        = 16;
    localparam int FB        = 8;
    localparam int DRAIN_CYC = 40;
    localparam int MAX_SHOWN = 10;
    localparam longint SAT_HI = 64'sd32767;
    localparam longint SAT_LO = -64'sd32768;

    typedef struct packed {
        logic signed [DW-1:0] re;
        logic signed [DW-1:0] im;
        logic [DW-1:0]        mag;
        logic                 ovf;
    } cplx_result_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [KIND_W-1:0]    i_kind = KIND_ADD;
    logic signed [DW-1:0] i_a_re = '0;
    logic signed [DW-1:0] i_a_im = '0;
    logic signed [DW-1:0] i_b_re = '0;
    logic signed [DW-1:0] i_b_im = '0;
    logic signed [DW-1:0] i_scale = '0;
    logic                 o_done;
    logic signed [DW-1:0] o_res_re;
    logic signed [DW-1:0] o_res_im;
    logic [DW-1:0]        o_magnitude;
    logic                 o_overflow;

    cplx_result_t pending_results[$];
    cplx_result_t got_beat;
    cplx_result_t want_beat;
    int           mismatch_count = 0;
    int           sender_idle_pct = 0;

    complex_arithmetic_unit #(
        .DATA_WIDTH(DW),
        .FRAC_BITS (FB)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_kind     (i_kind),
        .i_a_re     (i_a_re),
        .i_a_im     (i_a_im),
        .i_b_re     (i_b_re),
        .i_b_im     (i_b_im),
        .i_scale    (i_scale),
        .o_done     (o_done),
        .o_res_re   (o_res_re),
        .o_res_im   (o_res_im),
        .o_magnitude(o_magnitude),
        .o_overflow (o_overflow)
    );

    always #5 i_clk = ~i_clk;

    function automatic bit out_of_range(longint v);
        return (v > SAT_HI) || (v < SAT_LO);
    endfunction

    function automatic logic signed [DW-1:0] clamp(longint v);
        if (v > SAT_HI) begin
            return 16'sh7FFF;
        end
        if (v < SAT_LO) begin
            return 16'sh8000;
        end
        return DW'(v);
    endfunction

    function automatic longint unsigned root_floor(longint unsigned n);
        longint unsigned rem;
        longint unsigned res;
        longint unsigned b;
        rem = n;
        res = 0;
        b = 64'd1 << 62;
        while (b > rem) b = b >> 2;
        while (b != 0) begin
            if (rem >= res + b) begin
                rem = rem - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic cplx_result_t complex_op_result(
        t_kind k, logic signed [DW-1:0] ar, logic signed [DW-1:0] ai,
        logic signed [DW-1:0] br, logic signed [DW-1:0] bi, logic signed [DW-1:0] x);
        cplx_result_t r;
        longint       re_full;
        longint       im_full;
        longint       a_r;
        longint       a_i;
        longint       b_r;
        longint       b_i;
        longint       xs;
        a_r = longint'(ar);
        a_i = longint'(ai);
        b_r = longint'(br);
        b_i = longint'(bi);
        xs = longint'(x);
        r = '0;
        re_full = 0;
        im_full = 0;
        case (k)
            KIND_ADD: begin
                re_full = a_r + b_r;
                im_full = a_i + b_i;
            end
            KIND_SUB: begin
                re_full = a_r - b_r;
                im_full = a_i - b_i;
            end
            KIND_MUL_RE: begin
                re_full = (a_r * xs) >>> FB;
                im_full = (a_i * xs) >>> FB;
            end
            KIND_MUL_IM: begin
                re_full = (-(xs * a_i)) >>> FB;
                im_full = (xs * a_r) >>> FB;
            end
            KIND_CMUL: begin
                re_full = (a_r * b_r - a_i * b_i) >>> FB;
                im_full = (a_r * b_i + a_i * b_r) >>> FB;
            end
            KIND_MAG: begin
                r.mag = DW'(root_floor(longint'(unsigned'(a_r * a_r + a_i * a_i))));
            end
            default: begin
            end
        endcase
        r.re = clamp(re_full);
        r.im = clamp(im_full);
        r.ovf = out_of_range(re_full) || out_of_range(im_full);
        return r;
    endfunction

    function automatic logic signed [DW-1:0] pick_operand();
        int unsigned sel;
        sel = $urandom_range(9);
        case (sel)
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return DW'(int'($urandom_range(8)) - 4);
            3, 4: return DW'(int'($urandom_range(2047)) - 1024);
            default: return DW'($urandom);
        endcase
    endfunction

    task automatic send_cmd(t_kind k, logic signed [DW-1:0] ar, logic signed [DW-1:0] ai,
                            logic signed [DW-1:0] br, logic signed [DW-1:0] bi,
                            logic signed [DW-1:0] x);
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start   <= 1'b1;
        i_kind  <= k;
        i_a_re  <= ar;
        i_a_im  <= ai;
        i_b_re  <= br;
        i_b_im  <= bi;
        i_scale <= x;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_results.push_back(complex_op_result(k, ar, ai, br, bi, x));
    endtask

    task automatic test_add_sub();
        send_cmd(KIND_ADD, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh1234);
        send_cmd(KIND_ADD, 16'sh0100, -16'sh0080, 16'sh7EFF, 16'sh0080, 16'sh0000);
        send_cmd(KIND_SUB, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh0000);
        send_cmd(KIND_SUB, 16'sh0000, -16'sh0001, 16'sh0001, 16'sh7FFF, 16'shFFFF);
    endtask

    task automatic test_real_scale();
        send_cmd(KIND_MUL_RE, 16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh0000, 16'sh7FFF);
        send_cmd(KIND_MUL_RE, 16'sh8000, 16'sh8000, 16'sh0000, 16'sh0000, 16'sh8000);
        send_cmd(KIND_MUL_RE, 16'sh8000, 16'sh0001, 16'sh0000, 16'sh0000, -16'sh0001);
        send_cmd(KIND_MUL_RE, 16'sh0180, -16'sh0180, 16'sh1111, 16'sh2222, 16'sh0080);
    endtask

    task automatic test_imag_scale();
        // The negation of the full product comes before the floor shift.
        send_cmd(KIND_MUL_IM, 16'sh0001, 16'sh0001, 16'sh0000, 16'sh0000, 16'sh0001);
        send_cmd(KIND_MUL_IM, 16'sh8000, 16'sh8000, 16'sh0000, 16'sh0000, 16'sh8000);
        send_cmd(KIND_MUL_IM, 16'sh7FFF, -16'sh0003, 16'sh0000, 16'sh0000, -16'sh0055);
        send_cmd(KIND_MUL_IM, 16'sh0200, 16'sh0300, 16'sh7FFF, 16'sh8000, 16'sh0100);
    endtask

    task automatic test_complex_multiply();
        send_cmd(KIND_CMUL, 16'sh0100, 16'sh0000, 16'sh0000, 16'sh0100, 16'sh0000);
        send_cmd(KIND_CMUL, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh0000);
        send_cmd(KIND_CMUL, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh0000);
        send_cmd(KIND_CMUL, 16'sh0001, -16'sh0001, 16'sh0001, 16'sh0001, 16'sh7FFF);
        send_cmd(KIND_CMUL, 16'sh0180, 16'sh0240, -16'sh0100, 16'sh0080, 16'sh0000);
    endtask

    task automatic test_magnitude();
        send_cmd(KIND_MAG, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
        send_cmd(KIND_MAG, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
        send_cmd(KIND_MAG, 16'sh0300, -16'sh0400, 16'sh0000, 16'sh0000, 16'sh0000);
        send_cmd(KIND_MAG, 16'sh7FFF, 16'sh7FFF, 16'sh1234, 16'sh4321, 16'sh0F0F);
        send_cmd(KIND_MAG, 16'sh8000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
        send_cmd(KIND_MAG, 16'sh0001, -16'sh0001, 16'sh0000, 16'sh0000, 16'sh0000);
    endtask

    task automatic test_random_traffic(int n_items, int idle_pct);
        sender_idle_pct = idle_pct;
        repeat (n_items) begin
            send_cmd(t_kind'($urandom_range(5)), pick_operand(), pick_operand(),
                     pick_operand(), pick_operand(), pick_operand());
        end
    endtask

    // Each result beat is taken at the edge that ends its strobe cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            got_beat = '{o_res_re, o_res_im, o_magnitude, o_overflow};
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_SHOWN) begin
                    $display("result beat with nothing outstanding: re=%0d im=%0d mag=%0d ovf=%0b",
                             got_beat.re, got_beat.im, got_beat.mag, got_beat.ovf);
                end
            end else begin
                want_beat = pending_results.pop_front();
                if (got_beat !== want_beat) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_SHOWN) begin
                        $display("mismatch: expected re=%0d im=%0d mag=%0d ovf=%0b, got re=%0d im=%0d mag=%0d ovf=%0b",
                                 want_beat.re, want_beat.im, want_beat.mag, want_beat.ovf,
                                 got_beat.re, got_beat.im, got_beat.mag, got_beat.ovf);
                    end
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("tb_complex_arithmetic_unit: FAIL");
        $finish;
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        sender_idle_pct = 17;
        test_add_sub();
        test_real_scale();
        test_imag_scale();
        test_complex_multiply();
        test_magnitude();

        test_random_traffic(200, 17);
        test_random_traffic(200, 54);
        test_random_traffic(200, 0);

        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("tb_complex_arithmetic_unit: PASS");
        end else begin
            $display("tb_complex_arithmetic_unit: FAIL");
        end
        $finish;
    end

endmodule
